[hw/rtl/seed_hit_dedup_and_merge_top_defines.svh]
`ifndef SEED_HIT_DEDUP_AND_MERGE_TOP_DEFINES_SVH
`define SEED_HIT_DEDUP_AND_MERGE_TOP_DEFINES_SVH

// Checked at every clock edge outside reset.
`define SHDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every clock edge after the first, reset included.
`define SHDM_ASSERT_PAST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[hw/rtl/shdm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package shdm_pkg;

    localparam int MAX_HITS_DEF   = 64;
    localparam int DIAG_SLOTS_DEF = 4096;
    localparam int EPOCH_W        = 16;
    localparam int DIAG_W         = 18;

    localparam logic [11:0] QUERY_LENGTH_RST = 12'd150;
    localparam logic [11:0] MAX_GAP_RST      = 12'd5;
    localparam logic [7:0]  MISMATCH_RST     = 8'hFF;
    localparam logic [7:0]  GAP_OPEN_RST     = 8'hFB;
    localparam logic [7:0]  GAP_EXTEND_RST   = 8'hFE;

    typedef enum logic [2:0] {
        CFG_QUERY_LENGTH = 3'd0,
        CFG_MAX_GAP      = 3'd1,
        CFG_MISMATCH     = 3'd2,
        CFG_GAP_OPEN     = 3'd3,
        CFG_GAP_EXTEND   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]        ref_pos;
        logic [11:0]        ref_len;
        logic [11:0]        query_begin;
        logic [11:0]        query_end;
        logic signed [15:0] hit_score;
        logic [11:0]        mismatches;
        logic               batch_last;
    } t_hit_in;

    typedef struct packed {
        logic [31:0]        ref_pos;
        logic [11:0]        ref_len;
        logic [11:0]        query_begin;
        logic [11:0]        query_end;
        logic signed [15:0] hit_score;
        logic [11:0]        mismatches;
    } t_entry;

    typedef struct packed {
        logic [31:0]        out_ref_pos;
        logic [15:0]        out_ref_len;
        logic [11:0]        out_query_begin;
        logic [11:0]        out_query_end;
        logic signed [15:0] out_score;
        logic [11:0]        out_mismatches;
        logic               out_last;
    } t_res;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_LOAD,
        S_SORT_RDI,
        S_SORT_LDI,
        S_SORT_SCAN,
        S_SORT_WR,
        S_DD_RDO,
        S_DD_RDH,
        S_DD_MARK,
        S_DD_CHK,
        S_MG_RDK,
        S_MG_RDH,
        S_MG_HEAD,
        S_MG_RDKJ,
        S_MG_RDG,
        S_MG_CALC,
        S_MG_DEC,
        S_MG_EMIT,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/seed_hit_dedup_and_merge_top.sv]
// Seed hit deduplication and merge. Hits are loaded one per cycle while busy
// is low; the hit with batch_last set ends the batch and raises busy. The
// batch is then sorted by a rank count over the hit memory, deduplicated by
// diagonal (a mark memory read per hit and a write per kept hit), and merged
// greedily over one hit memory port. Results leave as one-cycle strobes on
// o_valid, which the receiver must take as they come; the last result of a
// batch carries out_last, and a batch with no result gives no strobe. After
// reset, and after a batch that brings the run epoch counter near its top, a
// clearing pass sweeps all DIAG_SLOTS entries of the mark memory with busy
// high. Configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

`include "seed_hit_dedup_and_merge_top_defines.svh"

module seed_hit_dedup_and_merge_top
    import shdm_pkg::*;
#(
    parameter int MAX_HITS   = MAX_HITS_DEF,
    parameter int DIAG_SLOTS = DIAG_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_hit_in     i_hit,
    output logic             o_valid,
    output t_res             o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [11:0] i_cfg_wdata
);

    localparam int AW  = $clog2(MAX_HITS);
    localparam int CW  = $clog2(MAX_HITS + 1);
    localparam int DAW = $clog2(DIAG_SLOTS);
    localparam logic [EPOCH_W-1:0] EPOCH_LIMIT =
        EPOCH_W'((1 << EPOCH_W) - 1 - MAX_HITS);

    // Configuration
    logic [11:0]       r_ql, r_gap;
    logic signed [7:0] r_mis, r_gopen, r_gext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ql    <= QUERY_LENGTH_RST;
            r_gap   <= MAX_GAP_RST;
            r_mis   <= MISMATCH_RST;
            r_gopen <= GAP_OPEN_RST;
            r_gext  <= GAP_EXTEND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_QUERY_LENGTH: r_ql    <= i_cfg_wdata;
                CFG_MAX_GAP:      r_gap   <= i_cfg_wdata;
                CFG_MISMATCH:     r_mis   <= i_cfg_wdata[7:0];
                CFG_GAP_OPEN:     r_gopen <= i_cfg_wdata[7:0];
                CFG_GAP_EXTEND:   r_gext  <= i_cfg_wdata[7:0];
                default:          ;
            endcase
        end
    end

    // Memories
    t_entry               hit_mem [MAX_HITS];
    logic [AW-1:0]        idx_mem [2*MAX_HITS];
    logic [EPOCH_W-1:0]   mark_mem [DIAG_SLOTS];
    t_entry               r_hm_rd;
    logic [AW-1:0]        r_im_rd;
    logic [EPOCH_W-1:0]   r_mk_rd;

    logic                 hm_we;
    logic [AW-1:0]        hm_waddr, hm_raddr;
    logic                 im_we;
    logic [AW:0]          im_waddr, im_raddr;
    logic [AW-1:0]        im_wdata;
    logic                 mk_we;
    logic [DAW-1:0]       mk_waddr, mk_raddr;
    logic [EPOCH_W-1:0]   mk_wdata;
    t_entry               c_in_entry;

    always_ff @(posedge i_clk) begin
        if (hm_we) begin
            hit_mem[hm_waddr] <= c_in_entry;
        end
        r_hm_rd <= hit_mem[hm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (im_we) begin
            idx_mem[im_waddr] <= im_wdata;
        end
        r_im_rd <= idx_mem[im_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            mark_mem[mk_waddr] <= mk_wdata;
        end
        r_mk_rd <= mark_mem[mk_raddr];
    end

    // Registers
    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, r_n, r_i, r_j, r_k, r_nk, r_rank;
    t_entry               r_hi, r_gd;
    logic [AW-1:0]        r_h, r_g;
    logic                 r_first;
    logic [31:0]          r_last, r_chunk;
    logic [EPOCH_W-1:0]   r_epoch;
    logic [DAW-1:0]       r_d, r_clr;
    logic [MAX_HITS-1:0]  r_cons;
    logic [31:0]          r_p0;
    logic [11:0]          r_qb0, r_qend;
    logic [32:0]          r_rb;
    logic signed [31:0]   r_acc_s;
    logic [18:0]          r_acc_m;
    logic                 r_c_ok, r_c_brk, r_gpos;
    logic signed [21:0]   r_pm, r_pe;
    t_res                 r_pend, r_out;
    logic                 r_have_pend, r_out_valid;

    logic                 c_accept;
    logic [CW-1:0]        c_cnt_next;

    assign c_accept   = start && !busy;
    assign c_in_entry = '{ref_pos: i_hit.ref_pos, ref_len: i_hit.ref_len,
                          query_begin: i_hit.query_begin, query_end: i_hit.query_end,
                          hit_score: i_hit.hit_score, mismatches: i_hit.mismatches};
    assign c_cnt_next = (r_cnt < CW'(MAX_HITS)) ? r_cnt + CW'(1) : r_cnt;

    // Sort: rank of hit i among all hits, stable on equal keys.
    logic c_peq, c_qbeq, c_before;
    always_comb begin
        c_peq    = r_hm_rd.ref_pos == r_hi.ref_pos;
        c_qbeq   = r_hm_rd.query_begin == r_hi.query_begin;
        c_before = (r_hm_rd.ref_pos < r_hi.ref_pos)
                || (c_peq && (r_hm_rd.query_begin < r_hi.query_begin))
                || (c_peq && c_qbeq && (r_hm_rd.query_end > r_hi.query_end))
                || (c_peq && c_qbeq && (r_hm_rd.query_end == r_hi.query_end)
                    && (r_j < r_i));
    end

    // Dedup: run detection and diagonal index.
    logic                 c_new_run;
    logic [31:0]          c_chunk, c_diff;
    logic signed [DIAG_W-1:0] c_d;
    logic                 c_d_ok, c_kept;
    logic [EPOCH_W-1:0]   c_ep_next;
    logic [CW-1:0]        c_nk_next;

    always_comb begin
        c_new_run = r_first || ((r_hm_rd.ref_pos != r_last)
                    && ({1'b0, r_hm_rd.ref_pos} != ({1'b0, r_last} + 33'd1)));
        c_chunk   = c_new_run ? r_hm_rd.ref_pos : r_chunk;
        // Inside a run the position grows by at most one per hit.
        c_diff    = r_hm_rd.ref_pos - c_chunk;
        c_d       = $signed(DIAG_W'(c_diff[CW-1:0])) + $signed(DIAG_W'(r_ql))
                  - $signed(DIAG_W'(r_hm_rd.query_begin));
        c_d_ok    = !c_d[DIAG_W-1] && (c_d < $signed(DIAG_W'(DIAG_SLOTS)));
        c_ep_next = c_new_run ? r_epoch + EPOCH_W'(1) : r_epoch;
        c_kept    = r_mk_rd != r_epoch;
        c_nk_next = c_kept ? r_nk + CW'(1) : r_nk;
    end

    // Merge: gap measures of candidate against the current merged hit.
    logic signed [34:0] c_gs, c_gq, c_dif, c_gsize, c_msize, c_gapw;
    logic signed [13:0] c_gq14;
    logic               c_ok, c_brk;
    logic signed [21:0] c_pm, c_pe;
    logic signed [23:0] c_gscore;
    logic signed [24:0] c_cand;
    logic               c_live, c_merge;

    always_comb begin
        c_gs    = $signed({3'b0, r_hm_rd.ref_pos}) - $signed({2'b0, r_rb}) - 35'sd1;
        c_gq14  = $signed({2'b0, r_hm_rd.query_begin}) - $signed({2'b0, r_qend}) - 14'sd1;
        c_gq    = 35'(c_gq14);
        c_dif   = c_gs - c_gq;
        c_gsize = c_dif[34] ? -c_dif : c_dif;
        c_msize = (c_gs < c_gq) ? c_gs : c_gq;
        c_gapw  = $signed({23'b0, r_gap});
        c_ok    = !c_gs[34] && !c_gq[34] && (c_msize <= c_gapw) && (c_gsize <= c_gapw);
        c_brk   = (c_gs > c_gapw) || (c_gq > c_gapw);
        c_pm    = $signed({1'b0, c_msize[12:0]}) * r_mis;
        c_pe    = $signed({1'b0, c_gsize[12:0]}) * r_gext;
        c_gscore = 24'(r_pm) + (r_gpos ? 24'(r_gopen) + 24'(r_pe) : 24'sd0);
        c_cand  = 25'(r_gd.hit_score) + 25'(c_gscore);
        c_live  = (r_gd.ref_len != 12'd0) && !r_cons[r_g];
        c_merge = c_live && r_c_ok && (c_cand > 25'sd0);
    end

    // Result formatting with saturation.
    logic signed [33:0] c_span;
    t_res               c_res;
    always_comb begin
        c_span = $signed({1'b0, r_rb}) - $signed({2'b0, r_p0}) + 34'sd1;
        c_res.out_ref_pos     = r_p0;
        c_res.out_ref_len     = (c_span > 34'sd65535) ? 16'hFFFF : c_span[15:0];
        c_res.out_query_begin = r_qb0;
        c_res.out_query_end   = r_qend;
        if (r_acc_s > 32'sd32767) begin
            c_res.out_score = 16'sh7FFF;
        end else if (r_acc_s < -32'sd32768) begin
            c_res.out_score = 16'sh8000;
        end else begin
            c_res.out_score = r_acc_s[15:0];
        end
        c_res.out_mismatches  = (r_acc_m > 19'd4095) ? 12'hFFF : r_acc_m[11:0];
        c_res.out_last        = 1'b0;
    end

    logic c_head_skip;
    assign c_head_skip = (r_hm_rd.ref_len == 12'd0) || r_cons[r_im_rd_h()];

    function automatic logic [AW-1:0] r_im_rd_h();
        return r_h;
    endfunction

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (r_clr == DAW'(DIAG_SLOTS - 1)) n_state = S_LOAD;
            S_LOAD:      if (c_accept && i_hit.batch_last) n_state = S_SORT_RDI;
            S_SORT_RDI:  n_state = S_SORT_LDI;
            S_SORT_LDI:  n_state = S_SORT_SCAN;
            S_SORT_SCAN: if (r_j + CW'(1) == r_n) n_state = S_SORT_WR;
            S_SORT_WR:   n_state = (r_i + CW'(1) == r_n) ? S_DD_RDO : S_SORT_RDI;
            S_DD_RDO:    n_state = S_DD_RDH;
            S_DD_RDH:    n_state = S_DD_MARK;
            S_DD_MARK: begin
                if (c_d_ok) begin
                    n_state = S_DD_CHK;
                end else if (r_k + CW'(1) == r_n) begin
                    n_state = (r_nk == '0) ? S_FINISH : S_MG_RDK;
                end else begin
                    n_state = S_DD_RDO;
                end
            end
            S_DD_CHK: begin
                if (r_k + CW'(1) == r_n) begin
                    n_state = (c_nk_next == '0) ? S_FINISH : S_MG_RDK;
                end else begin
                    n_state = S_DD_RDO;
                end
            end
            S_MG_RDK:    n_state = S_MG_RDH;
            S_MG_RDH:    n_state = S_MG_HEAD;
            S_MG_HEAD: begin
                if (c_head_skip) begin
                    n_state = (r_i + CW'(1) == r_nk) ? S_FINISH : S_MG_RDK;
                end else begin
                    n_state = (r_i + CW'(1) == r_nk) ? S_MG_EMIT : S_MG_RDKJ;
                end
            end
            S_MG_RDKJ:   n_state = S_MG_RDG;
            S_MG_RDG:    n_state = S_MG_CALC;
            S_MG_CALC:   n_state = S_MG_DEC;
            S_MG_DEC: begin
                if (!c_merge && r_c_brk) begin
                    n_state = S_MG_EMIT;
                end else begin
                    n_state = (r_j + CW'(1) == r_nk) ? S_MG_EMIT : S_MG_RDKJ;
                end
            end
            S_MG_EMIT:   n_state = (r_i + CW'(1) == r_nk) ? S_FINISH : S_MG_RDK;
            S_FINISH:    n_state = (r_epoch > EPOCH_LIMIT) ? S_CLEAR : S_LOAD;
            default:     n_state = S_CLEAR;
        endcase
    end

    // Memory port control
    always_comb begin
        hm_we    = 1'b0;
        hm_waddr = r_cnt[AW-1:0];
        hm_raddr = '0;
        im_we    = 1'b0;
        im_waddr = {1'b0, r_rank[AW-1:0]};
        im_wdata = r_i[AW-1:0];
        im_raddr = '0;
        mk_we    = 1'b0;
        mk_waddr = r_clr;
        mk_wdata = '0;
        mk_raddr = c_d[DAW-1:0];
        unique case (r_state)
            S_LOAD:      hm_we = c_accept && (r_cnt < CW'(MAX_HITS));
            S_CLEAR:     mk_we = 1'b1;
            S_SORT_RDI:  hm_raddr = r_i[AW-1:0];
            S_SORT_SCAN: hm_raddr = AW'(r_j + CW'(1));
            S_SORT_WR:   im_we = 1'b1;
            S_DD_RDO:    im_raddr = {1'b0, r_k[AW-1:0]};
            S_DD_RDH:    hm_raddr = r_im_rd;
            S_DD_CHK: begin
                im_we    = c_kept;
                im_waddr = {1'b1, r_nk[AW-1:0]};
                im_wdata = r_h;
                mk_we    = c_kept;
                mk_waddr = r_d;
                mk_wdata = r_epoch;
            end
            S_MG_RDK:    im_raddr = {1'b1, r_i[AW-1:0]};
            S_MG_RDH:    hm_raddr = r_im_rd;
            S_MG_RDKJ:   im_raddr = {1'b1, r_j[AW-1:0]};
            S_MG_RDG:    hm_raddr = r_im_rd;
            default:     ;
        endcase
    end

    // Datapath and control registers
    always_ff @(posedge i_clk) begin
        r_out_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_epoch     <= '0;
            r_cons      <= '0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b1;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + DAW'(1);
                    if (r_clr == DAW'(DIAG_SLOTS - 1)) begin
                        r_clr   <= '0;
                        r_epoch <= '0;
                    end
                end
                S_LOAD: begin
                    if (c_accept) begin
                        r_cnt <= c_cnt_next;
                        r_n   <= c_cnt_next;
                        r_i   <= '0;
                    end
                end
                S_SORT_RDI: ;
                S_SORT_LDI: begin
                    r_hi   <= r_hm_rd;
                    r_j    <= '0;
                    r_rank <= '0;
                end
                S_SORT_SCAN: begin
                    if (c_before) begin
                        r_rank <= r_rank + CW'(1);
                    end
                    r_j <= r_j + CW'(1);
                end
                S_SORT_WR: begin
                    r_i     <= r_i + CW'(1);
                    r_k     <= '0;
                    r_nk    <= '0;
                    r_first <= 1'b1;
                end
                S_DD_RDO: ;
                S_DD_RDH: r_h <= r_im_rd;
                S_DD_MARK: begin
                    r_first <= 1'b0;
                    r_last  <= r_hm_rd.ref_pos;
                    r_chunk <= c_chunk;
                    r_epoch <= c_ep_next;
                    r_d     <= c_d[DAW-1:0];
                    if (!c_d_ok) begin
                        r_k <= r_k + CW'(1);
                        r_i <= '0;
                    end
                end
                S_DD_CHK: begin
                    r_nk <= c_nk_next;
                    r_k  <= r_k + CW'(1);
                    r_i  <= '0;
                end
                S_MG_RDK: ;
                S_MG_RDH: r_h <= r_im_rd;
                S_MG_HEAD: begin
                    r_p0    <= r_hm_rd.ref_pos;
                    r_qb0   <= r_hm_rd.query_begin;
                    r_qend  <= r_hm_rd.query_end;
                    r_rb    <= {1'b0, r_hm_rd.ref_pos} + 33'(r_hm_rd.ref_len) - 33'd1;
                    r_acc_s <= 32'(r_hm_rd.hit_score);
                    r_acc_m <= 19'(r_hm_rd.mismatches);
                    r_j     <= r_i + CW'(1);
                    if (c_head_skip) begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_MG_RDKJ: ;
                S_MG_RDG: r_g <= r_im_rd;
                S_MG_CALC: begin
                    r_gd    <= r_hm_rd;
                    r_c_ok  <= c_ok;
                    r_c_brk <= c_brk;
                    r_pm    <= c_pm;
                    r_pe    <= c_pe;
                    r_gpos  <= c_gsize != 35'sd0;
                end
                S_MG_DEC: begin
                    if (c_merge) begin
                        r_qend     <= r_gd.query_end;
                        r_rb       <= {1'b0, r_gd.ref_pos} + 33'(r_gd.ref_len) - 33'd1;
                        r_acc_s    <= r_acc_s + 32'(c_cand);
                        r_acc_m    <= r_acc_m + 19'(r_gd.mismatches);
                        r_cons[r_g] <= 1'b1;
                    end
                    r_j <= r_j + CW'(1);
                end
                S_MG_EMIT: begin
                    // A result goes out only once it is known not to be the last.
                    r_out_valid <= r_have_pend;
                    r_out       <= r_pend;
                    r_pend      <= c_res;
                    r_have_pend <= 1'b1;
                    r_i         <= r_i + CW'(1);
                end
                S_FINISH: begin
                    r_out_valid     <= r_have_pend;
                    r_out           <= r_pend;
                    r_out.out_last  <= 1'b1;
                    r_have_pend     <= 1'b0;
                    r_cnt           <= '0;
                    r_cons          <= '0;
                    r_clr           <= '0;
                end
                default: ;
            endcase
        end
    end

    assign busy    = r_state != S_LOAD;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    `SHDM_ASSERT(a_out_source, o_valid |-> ($past(r_state) == S_MG_EMIT || $past(r_state) == S_FINISH), "result strobe outside emit")
    `SHDM_ASSERT(a_last_idle, (o_valid && o_res.out_last) |-> (r_state == S_LOAD || r_state == S_CLEAR), "last result while batch still in work")
    `SHDM_ASSERT(a_cnt_bound, r_cnt <= CW'(MAX_HITS), "hit count beyond capacity")
    `SHDM_ASSERT(a_merge_other, (r_state == S_MG_DEC && c_merge) |-> (r_g != r_h), "hit merged into itself")
    `SHDM_ASSERT_PAST(a_reset_quiet, $past(!i_rst_n) |-> !o_valid, "result strobe right after reset")

endmodule

`default_nettype wire
